@@ sv/tshm_pkg.sv @@
// Shared types and constants for the tabu solution hash memory.
`default_nettype none

package tshm_pkg;

	localparam int INDEX_W    = 10;
	localparam int INDEX_SPAN = 1 << INDEX_W;
	localparam int HASH_COUNT = 3;
	localparam int HASH_OUT_W = 16;

	typedef enum logic [2:0] {
		CMD_CLEAR       = 3'd0,
		CMD_RESTART     = 3'd1,
		CMD_SET         = 3'd2,
		CMD_CHECK_FLIP  = 3'd3,
		CMD_CHECK_SWAP  = 3'd4,
		CMD_COMMIT_FLIP = 3'd5,
		CMD_COMMIT_SWAP = 3'd6
	} command_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR_VIS,
		S_CLR_SOL,
		S_RD_A,
		S_CAP_A,
		S_CAP_B,
		S_PRED1,
		S_PRED2,
		S_VRD,
		S_VCHK,
		S_STORE,
		S_STORE_B,
		S_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;
		logic sweep_clr;
		logic sweep_inc;
		logic rd_sel_b;
		logic cap_a;
		logic cap_b;
		logic pred_en;
		logic pred_src_pred;
		logic pred_sub;
		logic pred_wsel_b;
		logic tabu_en;
		logic status_set;
		logic hash_store;
		logic hash_clr;
		logic sol_we;
		logic sol_sweep;
		logic sol_sel_b;
		logic sol_wdata;
		logic vis_we;
		logic vis_sweep;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		command_t command;
		logic     a_ok;
		logic     b_ok;
		logic     bit_a;
		logic     bit_b;
		logic     bit_value;
		logic     vis_last;
		logic     sol_last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ sv/tabu_solution_hash_memory.sv @@
// Top level of the tabu solution hash memory: controller, datapath and checks.
//
// The block holds a binary solution vector, three running solution hashes and three
// visited-bit tables of HASH_BUCKETS bits each. A request is taken when start is high
// and busy is low; the result appears for exactly one cycle with done high and cannot
// be held off. Requests run one at a time through a sequencer around single-port
// reads of the solution RAM and weight ROM (one partner per cycle) and one read or
// write of the visited RAMs. Clear tables sweeps the visited RAMs one address a
// cycle; restart sweeps the solution RAM, min(VARIABLES, 1024) addresses. After
// reset busy stays high while both RAMs clear.
`default_nettype none

module tabu_solution_hash_memory #(
	parameter int VARIABLES    = 1024,
	parameter int HASH_BUCKETS = 65536
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [2:0]                      command,
	input  wire logic [tshm_pkg::INDEX_W-1:0]    first_index,
	input  wire logic [tshm_pkg::INDEX_W-1:0]    second_index,
	input  wire logic                            bit_value,
	output logic                                 done,
	output logic                                 is_tabu,
	output logic                                 status,
	output logic      [tshm_pkg::HASH_OUT_W-1:0] hash_one,
	output logic      [tshm_pkg::HASH_OUT_W-1:0] hash_two,
	output logic      [tshm_pkg::HASH_OUT_W-1:0] hash_three
);

	import tshm_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	tshm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	tshm_datapath #(
		.VARIABLES    (VARIABLES),
		.HASH_BUCKETS (HASH_BUCKETS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (dp_cmd),
		.command      (command),
		.first_index  (first_index),
		.second_index (second_index),
		.bit_value    (bit_value),
		.stat         (dp_stat),
		.is_tabu      (is_tabu),
		.status       (status),
		.hash_one     (hash_one),
		.hash_two     (hash_two),
		.hash_three   (hash_three)
	);

`ifndef ASSERT_OFF
	// An accepted request keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a request");

	// After a result the block is ready for the next request
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after delivering a result");

	// A rejected swap is never reported as tabu
	a_tabu_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(is_tabu && status))
		else $error("result flags both tabu and rejected");

	// Visited marks and hash commits go together outside a clearing pass
	a_mark_store: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.vis_we && !dp_cmd.vis_sweep) |-> dp_cmd.hash_store)
		else $error("visited bit marked without a hash commit");
`endif

endmodule

`default_nettype wire

@@ sv/tshm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tshm_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write on enable, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/tshm_weight_rom.sv @@
// Build-time weight ROM: floor((n+1)^(g/10)) mod buckets for the three hashes.
`default_nettype none

module tshm_weight_rom #(
	parameter int DEPTH   = 1024,
	parameter int BUCKETS = 65536,
	localparam int HW = $clog2(BUCKETS),
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                              clk,
	input  wire logic [AW-1:0]                     raddr,
	output logic      [tshm_pkg::HASH_COUNT*HW-1:0] rdata
);

	import tshm_pkg::*;

	localparam int RAW_W  = 40;
	localparam int PROD_W = 512;
	localparam int unsigned GAMMA_TENTHS [HASH_COUNT] = '{19, 21, 23};

	// Largest m with m^10 <= x^g, by binary search in exact integers
	function automatic logic [RAW_W-1:0] weight_floor(input int unsigned x,
			input int unsigned g);
		logic [PROD_W-1:0] target;
		logic [PROD_W-1:0] trial;
		logic [RAW_W-1:0]  lo;
		logic [RAW_W-1:0]  hi;
		logic [RAW_W-1:0]  mid;
		target = PROD_W'(1);
		for (int i = 0; i < g; i++) begin
			target = target * PROD_W'(x);
		end
		lo = RAW_W'(x);
		hi = RAW_W'(x) * RAW_W'(x) * RAW_W'(x);
		while (lo < hi) begin
			mid = lo + ((hi - lo + RAW_W'(1)) >> 1);
			trial = PROD_W'(1);
			for (int i = 0; i < 10; i++) begin
				trial = trial * PROD_W'(mid);
			end
			if (trial <= target) begin
				lo = mid;
			end else begin
				hi = mid - RAW_W'(1);
			end
		end
		return lo;
	endfunction

	wire [HASH_COUNT*HW-1:0] rom_tab [DEPTH];

	// Fill the table at elaboration
	for (genvar i = 0; i < DEPTH; i++) begin : g_row
		for (genvar k = 0; k < HASH_COUNT; k++) begin : g_hash
			localparam logic [RAW_W-1:0] RAW = weight_floor(i + 1, GAMMA_TENTHS[k]);
			localparam logic [RAW_W-1:0] RED = RAW % RAW_W'(BUCKETS);
			assign rom_tab[i][k*HW +: HW] = RED[HW-1:0];
		end
	end

	// Register the read
	always_ff @(posedge clk) begin
		rdata <= rom_tab[raddr];
	end

endmodule

`default_nettype wire

@@ sv/tshm_ctrl.sv @@
// Controller state machine sequencing each request through the datapath.
`default_nettype none

module tshm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire tshm_pkg::dp_stat_t stat,
	output tshm_pkg::dp_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);

	import tshm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   init_q;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	// Hold state; start with the clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_VIS;
			init_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR_SOL && stat.sol_last) begin
				init_q <= 1'b0;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_RD_A;
				end
			end
			S_CLR_VIS: begin
				if (stat.vis_last) begin
					state_d = init_q ? S_CLR_SOL : S_DONE;
				end
			end
			S_CLR_SOL: begin
				if (stat.sol_last) begin
					state_d = init_q ? S_IDLE : S_DONE;
				end
			end
			S_RD_A: begin
				case (stat.command)
					CMD_CLEAR:       state_d = S_CLR_VIS;
					CMD_RESTART:     state_d = S_CLR_SOL;
					CMD_SET,
					CMD_CHECK_FLIP,
					CMD_COMMIT_FLIP: state_d = stat.a_ok ? S_CAP_A : S_DONE;
					CMD_CHECK_SWAP,
					CMD_COMMIT_SWAP: state_d = (stat.a_ok && stat.b_ok) ? S_CAP_A : S_DONE;
					default:         state_d = S_DONE;
				endcase
			end
			S_CAP_A: begin
				if (stat.command inside {CMD_CHECK_SWAP, CMD_COMMIT_SWAP}) begin
					state_d = S_CAP_B;
				end else begin
					state_d = S_PRED1;
				end
			end
			S_CAP_B: begin
				state_d = S_PRED1;
			end
			S_PRED1: begin
				case (stat.command)
					CMD_SET:         state_d = (stat.bit_a != stat.bit_value) ? S_STORE : S_DONE;
					CMD_CHECK_FLIP:  state_d = S_VRD;
					CMD_COMMIT_FLIP: state_d = S_STORE;
					CMD_CHECK_SWAP,
					CMD_COMMIT_SWAP: state_d = (stat.bit_a == stat.bit_b) ? S_DONE : S_PRED2;
					default:         state_d = S_DONE;
				endcase
			end
			S_PRED2: begin
				state_d = (stat.command == CMD_CHECK_SWAP) ? S_VRD : S_STORE;
			end
			S_VRD: begin
				state_d = S_VCHK;
			end
			S_VCHK: begin
				state_d = S_DONE;
			end
			S_STORE: begin
				state_d = (stat.command == CMD_COMMIT_SWAP) ? S_STORE_B : S_DONE;
			end
			S_STORE_B: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.sweep_clr = 1'b1;
				cmd.load_req  = accept;
			end
			S_CLR_VIS: begin
				cmd.vis_we    = 1'b1;
				cmd.vis_sweep = 1'b1;
				cmd.sweep_inc = 1'b1;
				cmd.sweep_clr = stat.vis_last;
			end
			S_CLR_SOL: begin
				cmd.sol_we    = 1'b1;
				cmd.sol_sweep = 1'b1;
				cmd.sol_wdata = 1'b0;
				cmd.sweep_inc = 1'b1;
				cmd.sweep_clr = stat.sol_last;
				cmd.hash_clr  = stat.sol_last;
			end
			S_RD_A: begin
				cmd.rd_sel_b = 1'b0;
			end
			S_CAP_A: begin
				cmd.cap_a    = 1'b1;
				cmd.rd_sel_b = 1'b1;
			end
			S_CAP_B: begin
				cmd.cap_b = 1'b1;
			end
			S_PRED1: begin
				// Single-weight flip, drop the falling partner of a swap, or reject a swap of equal bits
				case (stat.command)
					CMD_SET: begin
						cmd.pred_en  = (stat.bit_a != stat.bit_value);
						cmd.pred_sub = !stat.bit_value;
					end
					CMD_CHECK_FLIP,
					CMD_COMMIT_FLIP: begin
						cmd.pred_en  = 1'b1;
						cmd.pred_sub = stat.bit_a;
					end
					CMD_CHECK_SWAP,
					CMD_COMMIT_SWAP: begin
						if (stat.bit_a == stat.bit_b) begin
							cmd.status_set = 1'b1;
						end else begin
							cmd.pred_en     = 1'b1;
							cmd.pred_sub    = 1'b1;
							cmd.pred_wsel_b = !stat.bit_a;
						end
					end
					default: begin
						cmd.pred_en = 1'b0;
					end
				endcase
			end
			S_PRED2: begin
				// Add the rising partner of a swap
				cmd.pred_en       = 1'b1;
				cmd.pred_src_pred = 1'b1;
				cmd.pred_sub      = 1'b0;
				cmd.pred_wsel_b   = stat.bit_a;
			end
			S_VCHK: begin
				cmd.tabu_en = 1'b1;
			end
			S_STORE: begin
				cmd.hash_store = 1'b1;
				cmd.sol_we     = 1'b1;
				cmd.sol_sel_b  = 1'b0;
				cmd.sol_wdata  = (stat.command == CMD_SET) ? stat.bit_value : !stat.bit_a;
				cmd.vis_we     = (stat.command inside {CMD_COMMIT_FLIP, CMD_COMMIT_SWAP});
			end
			S_STORE_B: begin
				cmd.sol_we    = 1'b1;
				cmd.sol_sel_b = 1'b1;
				cmd.sol_wdata = !stat.bit_b;
			end
			S_DONE: begin
				done = 1'b1;
			end
			default: begin
				done = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/tshm_datapath.sv @@
// Datapath: request registers, solution and visited memories, weight ROM, hash arithmetic.
`default_nettype none

module tshm_datapath #(
	parameter int VARIABLES    = 1024,
	parameter int HASH_BUCKETS = 65536
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire tshm_pkg::dp_cmd_t                 cmd,
	input  wire logic [2:0]                        command,
	input  wire logic [tshm_pkg::INDEX_W-1:0]      first_index,
	input  wire logic [tshm_pkg::INDEX_W-1:0]      second_index,
	input  wire logic                              bit_value,
	output tshm_pkg::dp_stat_t                     stat,
	output logic                                   is_tabu,
	output logic                                   status,
	output logic      [tshm_pkg::HASH_OUT_W-1:0]   hash_one,
	output logic      [tshm_pkg::HASH_OUT_W-1:0]   hash_two,
	output logic      [tshm_pkg::HASH_OUT_W-1:0]   hash_three
);

	import tshm_pkg::*;

	localparam int SOL_DEPTH   = (VARIABLES < INDEX_SPAN) ? VARIABLES : INDEX_SPAN;
	localparam int SAW         = $clog2(SOL_DEPTH);
	localparam int HW          = $clog2(HASH_BUCKETS);
	localparam int SWEEP_DEPTH = (HASH_BUCKETS > SOL_DEPTH) ? HASH_BUCKETS : SOL_DEPTH;
	localparam int CW          = $clog2(SWEEP_DEPTH);
	localparam logic [HW:0] BUCKETS_X = (HW+1)'(HASH_BUCKETS);

	command_t                  command_q;
	logic [INDEX_W-1:0]        a_q;
	logic [INDEX_W-1:0]        b_q;
	logic                      v_q;
	logic                      bit_a_q;
	logic                      bit_b_q;
	logic [HASH_COUNT*HW-1:0]  wa_q;
	logic [HASH_COUNT*HW-1:0]  wb_q;
	logic [HW-1:0]             pred_q [HASH_COUNT];
	logic [HW-1:0]             hash_q [HASH_COUNT];
	logic [CW-1:0]             sweep_q;
	logic                      tabu_q;
	logic                      status_q;

	logic [SAW-1:0]            rd_addr;
	logic [SAW-1:0]            sol_waddr;
	logic                      sol_rdata;
	logic [HASH_COUNT*HW-1:0]  rom_rdata;
	logic [HASH_COUNT-1:0]     vis_rdata;

	logic [HW-1:0]             op_base [HASH_COUNT];
	logic [HW-1:0]             op_w    [HASH_COUNT];
	logic [HW:0]               op_sum  [HASH_COUNT];
	logic [HW:0]               op_dif  [HASH_COUNT];
	logic [HW-1:0]             op_res  [HASH_COUNT];

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			command_q <= command_t'(command);
			a_q       <= first_index;
			b_q       <= second_index;
			v_q       <= bit_value;
		end
	end

	// Advance the sweep counter for clearing passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_q <= '0;
		end else if (cmd.sweep_inc) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	// Select the partner being read
	assign rd_addr   = cmd.rd_sel_b ? b_q[SAW-1:0] : a_q[SAW-1:0];
	assign sol_waddr = cmd.sol_sweep ? sweep_q[SAW-1:0]
	                 : (cmd.sol_sel_b ? b_q[SAW-1:0] : a_q[SAW-1:0]);

	tshm_ram #(
		.WIDTH (1),
		.DEPTH (SOL_DEPTH)
	) u_solution (
		.clk   (clk),
		.we    (cmd.sol_we),
		.waddr (sol_waddr),
		.wdata (cmd.sol_wdata),
		.raddr (rd_addr),
		.rdata (sol_rdata)
	);

	tshm_weight_rom #(
		.DEPTH   (SOL_DEPTH),
		.BUCKETS (HASH_BUCKETS)
	) u_weights (
		.clk   (clk),
		.raddr (rd_addr),
		.rdata (rom_rdata)
	);

	// Capture partner bits and weights
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			bit_a_q <= sol_rdata;
			wa_q    <= rom_rdata;
		end
		if (cmd.cap_b) begin
			bit_b_q <= sol_rdata;
			wb_q    <= rom_rdata;
		end
	end

	// Modular add or subtract of one weight per hash
	always_comb begin
		for (int k = 0; k < HASH_COUNT; k++) begin
			op_base[k] = cmd.pred_src_pred ? pred_q[k] : hash_q[k];
			op_w[k]    = cmd.pred_wsel_b ? wb_q[k*HW +: HW] : wa_q[k*HW +: HW];
			op_sum[k]  = {1'b0, op_base[k]} + {1'b0, op_w[k]};
			op_dif[k]  = {1'b0, op_base[k]} - {1'b0, op_w[k]};
			if (cmd.pred_sub) begin
				op_res[k] = (op_base[k] < op_w[k]) ? HW'(op_dif[k] + BUCKETS_X)
				                                   : op_dif[k][HW-1:0];
			end else begin
				op_res[k] = (op_sum[k] >= BUCKETS_X) ? HW'(op_sum[k] - BUCKETS_X)
				                                     : op_sum[k][HW-1:0];
			end
		end
	end

	// Hold predicted hashes
	always_ff @(posedge clk) begin
		if (cmd.pred_en) begin
			for (int k = 0; k < HASH_COUNT; k++) begin
				pred_q[k] <= op_res[k];
			end
		end
	end

	// Commit or restart the solution hashes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HASH_COUNT; k++) begin
				hash_q[k] <= '0;
			end
		end else if (cmd.hash_clr) begin
			for (int k = 0; k < HASH_COUNT; k++) begin
				hash_q[k] <= '0;
			end
		end else if (cmd.hash_store) begin
			for (int k = 0; k < HASH_COUNT; k++) begin
				hash_q[k] <= pred_q[k];
			end
		end
	end

	// Visited tables, one per hash
	for (genvar k = 0; k < HASH_COUNT; k++) begin : g_visited
		tshm_ram #(
			.WIDTH (1),
			.DEPTH (HASH_BUCKETS)
		) u_visited (
			.clk   (clk),
			.we    (cmd.vis_we),
			.waddr (cmd.vis_sweep ? sweep_q[HW-1:0] : pred_q[k]),
			.wdata (!cmd.vis_sweep),
			.raddr (pred_q[k]),
			.rdata (vis_rdata[k])
		);
	end

	// Result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tabu_q   <= 1'b0;
			status_q <= 1'b0;
		end else if (cmd.load_req) begin
			tabu_q   <= 1'b0;
			status_q <= 1'b0;
		end else begin
			if (cmd.tabu_en) begin
				tabu_q <= &vis_rdata;
			end
			if (cmd.status_set) begin
				status_q <= 1'b1;
			end
		end
	end

	// Status back to the controller
	assign stat.command   = command_q;
	assign stat.a_ok      = 32'(a_q) < 32'(VARIABLES);
	assign stat.b_ok      = 32'(b_q) < 32'(VARIABLES);
	assign stat.bit_a     = bit_a_q;
	assign stat.bit_b     = bit_b_q;
	assign stat.bit_value = v_q;
	assign stat.vis_last  = (sweep_q == CW'(HASH_BUCKETS - 1));
	assign stat.sol_last  = (sweep_q == CW'(SOL_DEPTH - 1));

	assign is_tabu    = tabu_q;
	assign status     = status_q;
	assign hash_one   = HASH_OUT_W'(hash_q[0]);
	assign hash_two   = HASH_OUT_W'(hash_q[1]);
	assign hash_three = HASH_OUT_W'(hash_q[2]);

endmodule

`default_nettype wire

@@ tb/sv/tabu_solution_hash_memory_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the tabu solution hash memory: directed moves, then a random walk.

module tabu_solution_hash_memory_tb;
	import tshm_pkg::*;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 16;

	typedef bit [255:0] wide_t;

	typedef struct packed {
		bit        is_tabu;
		bit        status;
		bit [15:0] hash_one;
		bit [15:0] hash_two;
		bit [15:0] hash_three;
	} hash_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [2:0]            command;
	logic [INDEX_W-1:0]    first_index;
	logic [INDEX_W-1:0]    second_index;
	logic                  bit_value;
	logic                  done;
	logic                  is_tabu;
	logic                  status;
	logic [HASH_OUT_W-1:0] hash_one;
	logic [HASH_OUT_W-1:0] hash_two;
	logic [HASH_OUT_W-1:0] hash_three;

	// Local copy of the block state
	bit [INDEX_SPAN-1:0] sol_bits;
	bit [15:0]           run_hash [HASH_COUNT];
	bit                  visited_mark [int];
	bit [15:0]           hash_weight [HASH_COUNT][INDEX_SPAN];

	hash_result_t expected_hashes [$];
	int           error_count = 0;
	bit           idle_off = 1'b0;

	tabu_solution_hash_memory u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.first_index  (first_index),
		.second_index (second_index),
		.bit_value    (bit_value),
		.done         (done),
		.is_tabu      (is_tabu),
		.status       (status),
		.hash_one     (hash_one),
		.hash_two     (hash_two),
		.hash_three   (hash_three)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact floor((idx+1)^(tenths/10)) mod 2^16: largest m with m^10 <= (idx+1)^tenths
	function automatic bit [15:0] exact_weight(int idx, int tenths);
		wide_t     target;
		wide_t     m2;
		wide_t     m5;
		wide_t     m10;
		bit [31:0] lo;
		bit [31:0] hi;
		bit [31:0] mid;
		target = 1;
		for (int i = 0; i < tenths; i++)
			target = target * wide_t'(idx + 1);
		lo = 1;
		hi = (1 << 24) - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			m2  = wide_t'(mid) * wide_t'(mid);
			m5  = m2 * m2 * wide_t'(mid);
			m10 = m5 * m5;
			if (m10 <= target)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo[15:0];
	endfunction

	function automatic bit is_visited(int k, bit [15:0] h);
		return visited_mark.exists(k * 65536 + int'(h));
	endfunction

	// Advance the local state by one request and return its result
	function automatic hash_result_t predict_hash_result(logic [2:0] cmd, int a, int b, bit v);
		hash_result_t r;
		bit [15:0]    pred [HASH_COUNT];
		bit           have_move;
		bit           all_set;
		int           rise;
		int           fall;
		r = '0;
		have_move = 1'b0;
		a = a % INDEX_SPAN;
		b = b % INDEX_SPAN;
		case (cmd)
			CMD_CLEAR: visited_mark.delete();
			CMD_RESTART: begin
				sol_bits = '0;
				for (int k = 0; k < HASH_COUNT; k++)
					run_hash[k] = '0;
			end
			CMD_SET: begin
				if (sol_bits[a] != v) begin
					for (int k = 0; k < HASH_COUNT; k++)
						run_hash[k] = v ? run_hash[k] + hash_weight[k][a]
								: run_hash[k] - hash_weight[k][a];
					sol_bits[a] = v;
				end
			end
			CMD_CHECK_FLIP, CMD_COMMIT_FLIP: begin
				for (int k = 0; k < HASH_COUNT; k++)
					pred[k] = sol_bits[a] ? run_hash[k] - hash_weight[k][a]
							: run_hash[k] + hash_weight[k][a];
				have_move = 1'b1;
				if (cmd == CMD_COMMIT_FLIP)
					sol_bits[a] = ~sol_bits[a];
			end
			CMD_CHECK_SWAP, CMD_COMMIT_SWAP: begin
				if (sol_bits[a] == sol_bits[b]) begin
					r.status = 1'b1;
				end else begin
					rise = sol_bits[a] ? b : a;
					fall = sol_bits[a] ? a : b;
					for (int k = 0; k < HASH_COUNT; k++)
						pred[k] = run_hash[k] - hash_weight[k][fall] + hash_weight[k][rise];
					have_move = 1'b1;
					if (cmd == CMD_COMMIT_SWAP) begin
						sol_bits[rise] = 1'b1;
						sol_bits[fall] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		// Report tabu on a check, store and mark on a commit
		if (have_move) begin
			if (cmd == CMD_CHECK_FLIP || cmd == CMD_CHECK_SWAP) begin
				all_set = 1'b1;
				for (int k = 0; k < HASH_COUNT; k++)
					if (!is_visited(k, pred[k]))
						all_set = 1'b0;
				r.is_tabu = all_set;
			end else begin
				for (int k = 0; k < HASH_COUNT; k++) begin
					run_hash[k] = pred[k];
					visited_mark[k * 65536 + int'(pred[k])] = 1'b1;
				end
			end
		end
		r.hash_one   = run_hash[0];
		r.hash_two   = run_hash[1];
		r.hash_three = run_hash[2];
		return r;
	endfunction

	function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endfunction

	// Compare each result with the oldest pending expectation
	always @(posedge clk) begin : check_results
		hash_result_t want;
		if (done === 1'b1) begin
			if (expected_hashes.size() == 0) begin
				$error("result with no request pending");
				error_count++;
			end else begin
				want = expected_hashes.pop_front();
				check_field("is_tabu", 16'(want.is_tabu), 16'(is_tabu));
				check_field("status", 16'(want.status), 16'(status));
				check_field("hash_one", want.hash_one, hash_one);
				check_field("hash_two", want.hash_two, hash_two);
				check_field("hash_three", want.hash_three, hash_three);
			end
		end
	end

	// Send one request after a random gap; returns at the falling edge after acceptance
	task automatic send_request(input logic [2:0] cmd, input int a, input int b, input bit v);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command      <= cmd;
		first_index  <= a[INDEX_W-1:0];
		second_index <= b[INDEX_W-1:0];
		bit_value    <= v;
		start        <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		expected_hashes = {expected_hashes, predict_hash_result(cmd, a, b, v)};
		@(negedge clk);
	endtask

	// Hold off new requests until every pending result has arrived
	task automatic drain_results();
		start <= 1'b0;
		while (expected_hashes.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_reset_state();
		send_request(CMD_CHECK_FLIP, 0, 1023, 1'b1);
		send_request(CMD_UNUSED, 1023, 1023, 1'b1);
		send_request(CMD_CHECK_SWAP, 1023, 0, 1'b0);
	endtask

	task automatic test_set_bit();
		send_request(CMD_SET, 5, 0, 1'b1);
		send_request(CMD_SET, 5, 1023, 1'b1);
		send_request(CMD_SET, 5, 0, 1'b0);
		send_request(CMD_SET, 1023, 682, 1'b1);
		send_request(CMD_SET, 682, 341, 1'b1);
		send_request(CMD_SET, 341, 682, 1'b0);
	endtask

	task automatic test_flip_moves();
		send_request(CMD_COMMIT_FLIP, 0, 0, 1'b0);
		send_request(CMD_COMMIT_FLIP, 1023, 0, 1'b0);
		send_request(CMD_CHECK_FLIP, 1023, 0, 1'b0);
		send_request(CMD_CHECK_FLIP, 341, 0, 1'b0);
	endtask

	task automatic test_swap_moves();
		send_request(CMD_CHECK_SWAP, 1, 2, 1'b0);
		send_request(CMD_COMMIT_SWAP, 0, 0, 1'b0);
		send_request(CMD_COMMIT_SWAP, 0, 7, 1'b0);
		send_request(CMD_CHECK_SWAP, 0, 7, 1'b0);
		send_request(CMD_CHECK_SWAP, 7, 1023, 1'b1);
	endtask

	task automatic test_restart_and_clear();
		send_request(CMD_RESTART, 1023, 1023, 1'b1);
		send_request(CMD_CHECK_FLIP, 0, 0, 1'b0);
		drain_results();
		send_request(CMD_CLEAR, 1023, 1023, 1'b1);
		send_request(CMD_CHECK_FLIP, 0, 0, 1'b0);
		send_request(CMD_COMMIT_FLIP, 0, 0, 1'b0);
	endtask

	function automatic int pick_index(bit narrow);
		return narrow ? $urandom_range(0, 15) : $urandom_range(0, INDEX_SPAN - 1);
	endfunction

	// Mostly commits followed by checks of the reverse move, with some noise
	task automatic test_random_walk(input int items);
		int a;
		int b;
		int r;
		int last_a;
		int last_b;
		bit last_swap;
		bit narrow;
		bit v;
		last_a = 0;
		last_b = 0;
		last_swap = 1'b0;
		for (int n = 0; n < items; n++) begin
			if (n % 100 == 0)
				idle_off = ($urandom_range(0, 3) == 0);
			narrow = 1'($urandom_range(0, 1));
			a = pick_index(narrow);
			b = pick_index(narrow);
			r = $urandom_range(0, 99);
			v = 1'($urandom_range(0, 1));
			if (n % 450 == 449) begin
				drain_results();
				send_request(CMD_CLEAR, a, b, v);
			end else if (r < 28) begin
				send_request(CMD_COMMIT_FLIP, a, b, v);
				last_swap = 1'b0;
				last_a = a;
			end else if (r < 46) begin
				for (int t = 0; t < 8 && sol_bits[a] == sol_bits[b]; t++)
					b = pick_index(narrow);
				send_request(CMD_COMMIT_SWAP, a, b, v);
				last_swap = 1'b1;
				last_a = a;
				last_b = b;
			end else if (r < 64) begin
				send_request(last_swap ? CMD_CHECK_SWAP : CMD_CHECK_FLIP, last_a,
						last_swap ? last_b : b, v);
			end else if (r < 74) begin
				send_request(CMD_CHECK_FLIP, a, b, v);
			end else if (r < 82) begin
				send_request(CMD_CHECK_SWAP, a, b, v);
			end else if (r < 93) begin
				send_request(CMD_SET, a, b, v);
			end else if (r < 95) begin
				send_request(CMD_RESTART, a, b, v);
			end else if (r < 97) begin
				send_request(CMD_COMMIT_SWAP, a, narrow ? a : b, v);
			end else begin
				send_request(CMD_UNUSED, a, b, v);
			end
			if (n % 300 == 150)
				drain_results();
		end
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		command      = CMD_CLEAR;
		first_index  = '0;
		second_index = '0;
		bit_value    = 1'b0;
		sol_bits     = '0;
		for (int k = 0; k < HASH_COUNT; k++) begin
			run_hash[k] = '0;
			for (int n = 0; n < INDEX_SPAN; n++)
				hash_weight[k][n] = exact_weight(n, 19 + 2 * k);
		end
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_set_bit();
		test_flip_moves();
		test_swap_moves();
		test_restart_and_clear();
		drain_results();
		test_random_walk(1800);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
